>>> src/tdcb_pkg.sv
package tdcb_pkg;

    localparam int NUM_COMP    = 8;
    localparam int NUM_CH      = 4;
    localparam int CH_W        = 8;
    localparam int WORD_W      = NUM_CH * CH_W;
    localparam int COMP_IDX_W  = $clog2(NUM_COMP);
    localparam int PROD_W      = 2 * CH_W;
    localparam int SUM_W       = PROD_W + COMP_IDX_W;
    localparam int BLEND_SHIFT = 6;
    localparam int LVL_W       = SUM_W - BLEND_SHIFT;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [CH_W-1:0] CAP_RGB   = 8'd255;
    localparam logic [CH_W-1:0] CAP_ALPHA = 8'd128;

    typedef logic [NUM_COMP-1:0][CH_W-1:0] chan_vec_t;
    typedef logic [LVL_W-1:0]               level_t;
    typedef logic [NUM_CH-1:0][LVL_W-1:0]   level_vec_t;

    typedef struct packed {
        logic [WORD_W-1:0] color_c0;
        logic [WORD_W-1:0] color_c1;
        logic [WORD_W-1:0] color_c2;
        logic [WORD_W-1:0] color_c3;
        logic [WORD_W-1:0] color_c4;
        logic [WORD_W-1:0] color_c5;
        logic [WORD_W-1:0] color_c6;
        logic [WORD_W-1:0] color_c7;
    } color_word_t;

    typedef struct packed {
        logic [CH_W-1:0] out_r;
        logic [CH_W-1:0] out_g;
        logic [CH_W-1:0] out_b;
        logic [CH_W-1:0] out_a;
    } blend_word_t;

    // Stage load enables shared by every lane
    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } tdcb_ctl_t;

    function automatic logic [CH_W-1:0] sat_level(input level_t lvl, input logic [CH_W-1:0] cap);
        logic [CH_W-1:0] res;
        if (lvl > level_t'(cap))
        begin
            res = cap;
        end
        else
        begin
            res = lvl[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/tdcb_lane.sv
module tdcb_lane (
    input  logic                clk,
    input  tdcb_pkg::tdcb_ctl_t ctl,
    input  tdcb_pkg::chan_vec_t color,
    input  tdcb_pkg::chan_vec_t weight,
    output tdcb_pkg::level_t    level
);
    import tdcb_pkg::*;

    logic [PROD_W-1:0] prod_reg [NUM_COMP];
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;

    // Stage 1: one product per component
    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            for (int k = 0; k < NUM_COMP; k++)
            begin
                prod_reg[k] <= PROD_W'(color[k]) * PROD_W'(weight[k]);
            end
        end
    end

    // Stage 2: full-width sum, never wraps
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign level = sum_reg[SUM_W-1:BLEND_SHIFT];

endmodule

>>> src/tdcb_merge.sv
module tdcb_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s2_valid,
    input  tdcb_pkg::level_vec_t  levels,
    output logic                  load,
    output logic                  blend_valid,
    input  logic                  blend_ready,
    output tdcb_pkg::blend_word_t blend
);
    import tdcb_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    blend_word_t word_reg;
    blend_word_t word_next;

    assign load = !valid_reg || blend_ready;

    always_comb
    begin
        valid_next      = load ? s2_valid : valid_reg;
        word_next.out_r = sat_level(levels[CH_RED], CAP_RGB);
        word_next.out_g = sat_level(levels[CH_GREEN], CAP_RGB);
        word_next.out_b = sat_level(levels[CH_BLUE], CAP_RGB);
        word_next.out_a = sat_level(levels[CH_ALPHA], CAP_ALPHA);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && s2_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign blend_valid = valid_reg;
    assign blend       = word_reg;

endmodule

>>> src/time_of_day_color_blend_unit.sv
// Time-of-day color blend.
// Input channel (color_valid / color_ready / color): one word per palette
// entry, eight RGBA components of four 8-bit channels each.
// Output channel (blend_valid / blend_ready / blend): one blended RGBA word
// per input word, in order. Each channel is the sum over the eight components
// of color times weight, shifted right by 6 (weight 64 is unity), capped at
// 255 for red, green and blue and at 128 for alpha.
// Configuration: cfg_wen writes cfg_data into weight register cfg_index
// (component 0..7, byte k is the weight of channel k). Write only when idle.
// Pipeline: the product register loads at the accepting edge, then the sum
// register, then the output register, which raises blend_valid. Throughput:
// one word per cycle while the receiver takes every word; four channel lanes
// each carry eight 8x8 multipliers and an adder tree.
// Reset clears the weights to zero and empties the pipeline.
// When the receiver stalls, the output register holds its word; the earlier
// stages keep filling until all three are full, and only then does
// color_ready drop.
module time_of_day_color_blend_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [tdcb_pkg::COMP_IDX_W-1:0]     cfg_index,
    input  logic [tdcb_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                color_valid,
    output logic                                color_ready,
    input  tdcb_pkg::color_word_t               color,
    output logic                                blend_valid,
    input  logic                                blend_ready,
    output tdcb_pkg::blend_word_t               blend
);
    import tdcb_pkg::*;

    logic [NUM_COMP-1:0][WORD_W-1:0] weight_reg;
    logic [NUM_COMP-1:0][WORD_W-1:0] comp_color;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            s2_valid_reg;
    logic                            s2_valid_next;
    logic                            out_load;
    tdcb_ctl_t                       ctl;
    level_vec_t                      levels;

    // Weight registers: plain indexed write, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else if (cfg_wen)
        begin
            weight_reg[cfg_index] <= cfg_data;
        end
    end

    // Each stage advances when it is empty or the next stage takes its word
    always_comb
    begin
        ctl.s2_load   = !s2_valid_reg || out_load;
        ctl.s1_load   = !s1_valid_reg || ctl.s2_load;
        s1_valid_next = ctl.s1_load ? color_valid : s1_valid_reg;
        s2_valid_next = ctl.s2_load ? s1_valid_reg : s2_valid_reg;
    end

    assign color_ready = ctl.s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Gather the components so each lane can slice its channel byte
    assign comp_color[0] = color.color_c0;
    assign comp_color[1] = color.color_c1;
    assign comp_color[2] = color.color_c2;
    assign comp_color[3] = color.color_c3;
    assign comp_color[4] = color.color_c4;
    assign comp_color[5] = color.color_c5;
    assign comp_color[6] = color.color_c6;
    assign comp_color[7] = color.color_c7;

    // One lane per channel
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        chan_vec_t lane_color;
        chan_vec_t lane_weight;

        for (genvar k = 0; k < NUM_COMP; k++)
        begin : g_comp
            assign lane_color[k]  = comp_color[k][ch*CH_W +: CH_W];
            assign lane_weight[k] = weight_reg[k][ch*CH_W +: CH_W];
        end

        tdcb_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .color  (lane_color),
            .weight (lane_weight),
            .level  (levels[ch])
        );
    end

    // Cap each channel and hold the result for the receiver
    tdcb_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2_valid    (s2_valid_reg),
        .levels      (levels),
        .load        (out_load),
        .blend_valid (blend_valid),
        .blend_ready (blend_ready),
        .blend       (blend)
    );

endmodule

>>> src/tdcb_checker.sv
module tdcb_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                color_valid,
    input logic                                color_ready,
    input logic                                blend_valid,
    input logic                                blend_ready,
    input tdcb_pkg::blend_word_t               blend
);
    import tdcb_pkg::*;

    // Pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !blend_valid)
        else $error("blend_valid high after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && !blend_ready |=> blend_valid && $stable(blend))
        else $error("stalled blend word changed");

    // Input backs up only when the output is stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !color_ready |-> blend_valid && !blend_ready)
        else $error("color_ready low without output stall");

    // Alpha never exceeds its cap
    a_alpha_cap: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid |-> blend.out_a <= CAP_ALPHA)
        else $error("alpha above cap");

    // A new result follows an accepted word by the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blend_valid) |-> $past(color_valid && color_ready, 3))
        else $error("result without matching input");

endmodule

bind time_of_day_color_blend_unit tdcb_checker u_tdcb_checker (.*);

>>> bench/tb_top.sv
module tb_top;
    import tdcb_pkg::*;

    // Percent of cycles in which a side idles while not in a calm phase
    localparam int IDLE_PCT   = 25;
    // Length of the one long receiver hold-off, in cycles
    localparam int HOLD_LEN   = 80;
    // Settle time after the last blend word; pipeline is three stages deep
    localparam int SETTLE     = 6;
    localparam int MAX_SHOWN  = 10;
    localparam int RAND_PHASES = 6;
    localparam int RAND_WORDS  = 172;
    localparam logic [WORD_W-1:0] UNITY = 32'h40404040;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [COMP_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]     cfg_data;
    logic                  color_valid;
    logic                  color_ready;
    color_word_t           color;
    logic                  blend_valid;
    logic                  blend_ready;
    blend_word_t           blend;

    // Color words waiting to be offered, and blend words the block owes us
    color_word_t pending_colors[$];
    blend_word_t expected_blends[$];

    // Our copy of the weight registers, and the next set to load
    logic [WORD_W-1:0] weight_mirror [NUM_COMP];
    logic [WORD_W-1:0] weight_plan   [NUM_COMP];

    int unsigned mismatches;

    // calm: neither side idles. hold_armed: receiver takes its long hold-off.
    bit          calm;
    bit          hold_armed;
    logic        hold_off;
    logic        hold_done;
    int unsigned hold_cnt;

    time_of_day_color_blend_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .color_valid (color_valid),
        .color_ready (color_ready),
        .color       (color),
        .blend_valid (blend_valid),
        .blend_ready (blend_ready),
        .blend       (blend)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Expected blend for one color word under the mirrored weights:
    // per channel, full-width sum of color times weight over the eight
    // components, drop six fraction bits, then cap (alpha caps lower).
    function automatic blend_word_t blend_of(input color_word_t w);
        logic [WORD_W-1:0] comp [NUM_COMP];
        logic [CH_W-1:0]   lane [NUM_CH];
        int unsigned       acc;
        int unsigned       lvl;
        int unsigned       cap;
        int                ch;
        int                k;
        blend_word_t       r;
        comp[0] = w.color_c0;
        comp[1] = w.color_c1;
        comp[2] = w.color_c2;
        comp[3] = w.color_c3;
        comp[4] = w.color_c4;
        comp[5] = w.color_c5;
        comp[6] = w.color_c6;
        comp[7] = w.color_c7;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            acc = 0;
            for (k = 0; k < NUM_COMP; k++)
            begin
                acc += 32'(comp[k][ch*CH_W +: CH_W]) * 32'(weight_mirror[k][ch*CH_W +: CH_W]);
            end
            lvl = acc >> BLEND_SHIFT;
            cap = (ch == CH_ALPHA) ? 32'(CAP_ALPHA) : 32'(CAP_RGB);
            if (lvl > cap)
            begin
                lvl = cap;
            end
            lane[ch] = CH_W'(lvl);
        end
        r.out_r = lane[CH_RED];
        r.out_g = lane[CH_GREEN];
        r.out_b = lane[CH_BLUE];
        r.out_a = lane[CH_ALPHA];
        return r;
    endfunction

    // Color word with every component set to the same RGBA value
    function automatic color_word_t all_comps(input logic [WORD_W-1:0] v);
        return color_word_t'({NUM_COMP{v}});
    endfunction

    // Color word with only component k set; component 0 sits in the top bits
    function automatic color_word_t one_comp(input int k, input logic [WORD_W-1:0] v);
        logic [NUM_COMP*WORD_W-1:0] flat;
        flat = '0;
        flat[(NUM_COMP-1-k)*WORD_W +: WORD_W] = v;
        return color_word_t'(flat);
    endfunction

    // Random channel byte, skewed toward the extremes so saturation and
    // all-zero lanes show up often
    function automatic logic [CH_W-1:0] rand_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            return '0;
        end
        else if (roll < 24)
        begin
            return '1;
        end
        return CH_W'($urandom_range(255));
    endfunction

    function automatic color_word_t rand_color();
        logic [NUM_COMP*WORD_W-1:0] flat;
        int                         i;
        for (i = 0; i < NUM_COMP * NUM_CH; i++)
        begin
            flat[i*CH_W +: CH_W] = rand_byte();
        end
        return color_word_t'(flat);
    endfunction

    // Compare one blend word with the oldest expectation, field by field
    task automatic check_blend(input blend_word_t got);
        blend_word_t want;
        if (expected_blends.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
            begin
                $display("unexpected blend word: r=%0d g=%0d b=%0d a=%0d",
                         got.out_r, got.out_g, got.out_b, got.out_a);
            end
        end
        else
        begin
            want = expected_blends.pop_front();
            if (got.out_r !== want.out_r || got.out_g !== want.out_g ||
                got.out_b !== want.out_b || got.out_a !== want.out_a)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("blend mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                             want.out_r, want.out_g, want.out_b, want.out_a,
                             got.out_r, got.out_g, got.out_b, got.out_a);
                end
            end
        end
    endtask

    // Driver: offer the next pending color word. Hold valid and payload
    // until accepted; predict the blend at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid <= 1'b0;
            color       <= '0;
        end
        else
        begin
            if (color_valid && color_ready)
            begin
                expected_blends.push_back(blend_of(color));
            end
            if (!color_valid || color_ready)
            begin
                if (pending_colors.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    color       <= pending_colors.pop_front();
                    color_valid <= 1'b1;
                end
                else
                begin
                    color_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted blend word, then pick next cycle's ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_ready <= 1'b0;
        end
        else
        begin
            if (blend_valid && blend_ready)
            begin
                check_blend(blend);
            end
            blend_ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long receiver hold-off: once armed, drop ready until hold_cnt reaches HOLD_LEN so
    // the pipeline fills and the block has to stall color_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (hold_armed && !hold_done)
        begin
            if (hold_cnt < HOLD_LEN)
            begin
                hold_off <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end
            else
            begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
        end
    end

    // Wait until every queued word went in and every blend came back, then
    // give the pipeline its settle time. Poll on the falling edge so the
    // reads never race the driver or monitor.
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_colors.size() != 0 || color_valid || expected_blends.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write all eight weight registers back to back from weight_plan;
    // keep the enable high across the burst, drop it after the last write
    task automatic load_weights();
        int k;
        for (k = 0; k < NUM_COMP; k++)
        begin
            @(posedge clk);
            cfg_wen   <= 1'b1;
            cfg_index <= COMP_IDX_W'(k);
            cfg_data  <= weight_plan[k];
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
        for (k = 0; k < NUM_COMP; k++)
        begin
            weight_mirror[k] = weight_plan[k];
        end
        @(negedge clk);
    endtask

    // Random weight set; the style varies per phase so some phases blend
    // gently and others saturate almost everywhere
    task automatic plan_random_weights(input int phase);
        int k;
        int b;
        logic [CH_W-1:0] wb;
        for (k = 0; k < NUM_COMP; k++)
        begin
            for (b = 0; b < NUM_CH; b++)
            begin
                if (phase % 3 == 0)
                begin
                    wb = CH_W'($urandom_range(16));
                end
                else if (phase % 3 == 1)
                begin
                    wb = CH_W'($urandom_range(255) >> $urandom_range(7));
                end
                else
                begin
                    wb = CH_W'($urandom_range(255));
                end
                weight_plan[k][b*CH_W +: CH_W] = wb;
            end
        end
    endtask

    initial
    begin
        int k;
        int p;
        int n;
        rst_n      <= 1'b0;
        cfg_wen    <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        calm       = 1'b0;
        hold_armed = 1'b0;
        mismatches = 0;
        for (k = 0; k < NUM_COMP; k++)
        begin
            weight_mirror[k] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Weights still at reset: every blend must come out zero
        pending_colors.push_back(all_comps('1));
        pending_colors.push_back(rand_color());
        drain();

        // Unity weight on component 0 only: pass-through, alpha capped at 128
        for (k = 0; k < NUM_COMP; k++)
        begin
            weight_plan[k] = '0;
        end
        weight_plan[0] = UNITY;
        load_weights();
        pending_colors.push_back(one_comp(0, 32'h807f00ff));
        pending_colors.push_back(one_comp(0, 32'h81ffffff));
        pending_colors.push_back(one_comp(0, 32'h7f010203));
        pending_colors.push_back(one_comp(7, 32'hffffffff));
        pending_colors.push_back(all_comps('1));
        drain();

        // Every weight at max: largest sums, heavy saturation; a single
        // lsb in one component lands at three after the shift
        for (k = 0; k < NUM_COMP; k++)
        begin
            weight_plan[k] = '1;
        end
        load_weights();
        pending_colors.push_back(all_comps('1));
        pending_colors.push_back(all_comps('0));
        pending_colors.push_back(all_comps(32'h55555555));
        pending_colors.push_back(all_comps(32'haaaaaaaa));
        for (k = 0; k < NUM_COMP; k++)
        begin
            pending_colors.push_back(one_comp(k, 32'h01010101));
        end
        drain();

        // Random phases; phase 1 runs with no idling at all, phase 3 adds
        // the long receiver hold-off while the sender keeps pushing
        for (p = 0; p < RAND_PHASES; p++)
        begin
            plan_random_weights(p);
            load_weights();
            calm       = (p == 1 || p == 3);
            hold_armed = (p == 3);
            for (n = 0; n < RAND_WORDS; n++)
            begin
                pending_colors.push_back(rand_color());
            end
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
src/tdcb_pkg.sv
src/tdcb_lane.sv
src/tdcb_merge.sv
src/time_of_day_color_blend_unit.sv
src/tdcb_checker.sv
bench/tb_top.sv
